FILE: hw/rtl/msble_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msble_pkg;

	typedef enum logic [3:0] {
		CMD_CREATE  = 4'd0,
		CMD_APPEND  = 4'd1,
		CMD_POP     = 4'd2,
		CMD_DELETE  = 4'd3,
		CMD_RESIZE  = 4'd4,
		CMD_COUNT   = 4'd5,
		CMD_READ    = 4'd6,
		CMD_SORTED  = 4'd7,
		CMD_RELEASE = 4'd8
	} cmd_e_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_BAD_SLOT  = 4'd1,
		ST_EXISTS    = 4'd2,
		ST_BAD_SIZE  = 4'd3,
		ST_NO_MEM    = 4'd4,
		ST_NO_LIST   = 4'd5,
		ST_FULL      = 4'd6,
		ST_EMPTY     = 4'd7,
		ST_NOT_FOUND = 4'd8,
		ST_BAD_NEW   = 4'd9
	} status_e_t;

	typedef enum logic [2:0] {
		OUT_PRE,
		OUT_NF,
		OUT_DEL,
		OUT_ELEM,
		OUT_BEST
	} out_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_SINGLE,
		S_DRD,
		S_DCHK,
		S_NF,
		S_SRD,
		S_SWR,
		S_DDONE,
		S_RRD,
		S_ROUT,
		S_TRD,
		S_TCMP,
		S_TOUT
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     start;
		logic     idx_inc;
		logic     mem_rd;
		logic     rd_next;
		logic     shift_wr;
		logic     best_upd;
		logic     next_pass;
		logic     commit;
		logic     out_ld;
		out_sel_t out_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       cmd_known;
		logic       long_op;
		logic       match;
		logic       idx_last;
		logic       next_avail;
		logic       k_last;
		logic       out_free;
	} dp_stat_t;

	localparam int DATA_W = 32;

endpackage
`default_nettype wire

FILE: hw/rtl/msble_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module msble_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  msble_pkg::dp_stat_t  stat,
	output msble_pkg::ctl_cmd_t  cmd
);
	import msble_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.out_sel = OUT_PRE;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.start = 1'b1;
				if (!stat.cmd_known) begin
					state_d = S_IDLE;
				end else if (!stat.long_op) begin
					state_d = S_SINGLE;
				end else begin
					case (stat.cmd)
						CMD_DELETE: state_d = S_DRD;
						CMD_SORTED: state_d = S_TRD;
						default:    state_d = S_RRD;
					endcase
				end
			end
			S_SINGLE: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DRD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_DCHK;
			end
			S_DCHK: begin
				if (stat.match) begin
					state_d = S_SRD;
				end else if (stat.idx_last) begin
					state_d = S_NF;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_DRD;
				end
			end
			S_NF: begin
				cmd.out_sel = OUT_NF;
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SRD: begin
				if (stat.next_avail) begin
					cmd.mem_rd  = 1'b1;
					cmd.rd_next = 1'b1;
					state_d = S_SWR;
				end else begin
					state_d = S_DDONE;
				end
			end
			S_SWR: begin
				cmd.shift_wr = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d = S_SRD;
			end
			S_DDONE: begin
				cmd.out_sel = OUT_DEL;
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RRD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_ROUT;
			end
			S_ROUT: begin
				cmd.out_sel = OUT_ELEM;
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					if (stat.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_RRD;
					end
				end
			end
			S_TRD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_TCMP;
			end
			S_TCMP: begin
				cmd.best_upd = 1'b1;
				if (stat.idx_last) begin
					state_d = S_TOUT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_TRD;
				end
			end
			S_TOUT: begin
				cmd.out_sel = OUT_BEST;
				if (stat.out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.next_pass = 1'b1;
					state_d = stat.k_last ? S_IDLE : S_TRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/msble_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module msble_dp #(
	parameter int NUM_SLOTS = 10,
	parameter int MAX_CAP   = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [47:0]          s_tdata,
	input  wire  [3:0]           s_tuser,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [47:0]          m_tdata,
	output logic [0:0]           m_tuser,
	output logic                 m_tlast,
	input  msble_pkg::ctl_cmd_t  cmd,
	output msble_pkg::dp_stat_t  stat
);
	import msble_pkg::*;

	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW    = $clog2(MAX_CAP + 1);
	localparam int DEPTH = NUM_SLOTS * MAX_CAP;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [8:0] MAXC9 = 9'(MAX_CAP);

	logic [3:0]               cmd_q;
	logic [3:0]               slot_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [7:0]        size_q;

	logic                     ex_q  [NUM_SLOTS];
	logic [CW-1:0]            cap_q [NUM_SLOTS];
	logic [CW-1:0]            fill_q[NUM_SLOTS];

	logic [DATA_W-1:0]        mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	logic [CW-1:0]            idx_q, k_q, best_idx_q, prev_idx_q;
	logic signed [DATA_W-1:0] best_val_q, prev_val_q;
	logic                     best_valid_q;

	logic                     slot_ok, exists;
	logic [SW-1:0]            s;
	logic [CW-1:0]            n, cap, n_m1, nc_c, fill_rs;
	logic signed [8:0]        nc;
	logic [3:0]               pre_status;
	logic [CW-1:0]            pre_fill;
	logic                     long_op, cmd_known;
	logic [AW-1:0]            base, raddr, waddr;
	logic [DATA_W-1:0]        wdata;
	logic                     we;
	logic                     gt_prev, lt_best, cand;
	logic                     out_free;

	assign slot_ok = (slot_q >= 4'd1) && ({1'b0, slot_q} <= 5'(NUM_SLOTS));
	assign s       = slot_ok ? SW'(slot_q - 4'd1) : '0;
	assign exists  = ex_q[s];
	assign n       = fill_q[s];
	assign cap     = cap_q[s];
	assign n_m1    = n - 1'b1;
	assign nc      = $signed({1'b0, 8'(cap)}) + 9'(size_q);
	assign nc_c    = CW'(nc);
	assign fill_rs = (n > nc_c) ? nc_c : n;
	assign base    = AW'(s) * AW'(MAX_CAP);

	always_comb begin
		pre_status = ST_OK;
		pre_fill   = '0;
		long_op    = 1'b0;
		cmd_known  = (cmd_q <= CMD_RELEASE);
		if (cmd_q == CMD_CREATE) begin
			if (size_q < 8'sd1)           pre_status = ST_BAD_SIZE;
			else if (!slot_ok)            pre_status = ST_BAD_SLOT;
			else if (exists)              pre_status = ST_EXISTS;
			else if (9'(size_q) > MAXC9)  pre_status = ST_NO_MEM;
			pre_fill = (slot_ok && exists) ? n : '0;
		end else if (cmd_q == CMD_RELEASE) begin
			pre_status = ST_OK;
		end else if (!slot_ok) begin
			pre_status = ST_BAD_SLOT;
		end else if (!exists) begin
			pre_status = ST_NO_LIST;
		end else begin
			case (cmd_q)
				CMD_APPEND: begin
					if (n >= cap) begin
						pre_status = ST_FULL;
						pre_fill   = n;
					end else begin
						pre_fill = CW'(n + 1'b1);
					end
				end
				CMD_RESIZE: begin
					pre_fill = fill_rs;
					if (nc < 9'sd1) begin
						pre_status = ST_BAD_NEW;
						pre_fill   = n;
					end else if (nc > MAXC9) begin
						pre_status = ST_NO_MEM;
						pre_fill   = n;
					end
				end
				CMD_POP, CMD_DELETE, CMD_COUNT, CMD_READ, CMD_SORTED: begin
					if (n == '0) begin
						pre_status = ST_EMPTY;
					end else begin
						pre_fill = (cmd_q == CMD_POP) ? n_m1 : n;
						long_op  = (cmd_q == CMD_DELETE) || (cmd_q == CMD_READ) ||
							(cmd_q == CMD_SORTED);
					end
				end
				default: pre_status = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= s_tuser;
			slot_q  <= s_tdata[3:0];
			value_q <= s_tdata[35:4];
			size_q  <= s_tdata[43:36];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ex_q[i]   <= 1'b0;
				cap_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (cmd_q == CMD_RELEASE) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					ex_q[i]   <= 1'b0;
					cap_q[i]  <= '0;
					fill_q[i] <= '0;
				end
			end else if (pre_status == ST_OK) begin
				case (cmd_q)
					CMD_CREATE: begin
						ex_q[s]   <= 1'b1;
						cap_q[s]  <= CW'(size_q);
						fill_q[s] <= '0;
					end
					CMD_APPEND: fill_q[s] <= CW'(n + 1'b1);
					CMD_POP:    fill_q[s] <= n_m1;
					CMD_DELETE: fill_q[s] <= n_m1;
					CMD_RESIZE: begin
						cap_q[s]  <= nc_c;
						fill_q[s] <= fill_rs;
					end
					default: ;
				endcase
			end
		end
	end

	assign raddr = base + AW'(idx_q) + AW'(cmd.rd_next);
	assign we    = cmd.shift_wr ||
		(cmd.commit && (cmd_q == CMD_APPEND) && (pre_status == ST_OK));
	assign waddr = cmd.shift_wr ? (base + AW'(idx_q)) : (base + AW'(n));
	assign wdata = cmd.shift_wr ? rdata_q : value_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rdata_q <= mem[raddr];
		end
	end

	assign gt_prev = (rdata_q > prev_val_q) ||
		((rdata_q == prev_val_q) && (idx_q > prev_idx_q));
	assign lt_best = (rdata_q < best_val_q) ||
		((rdata_q == best_val_q) && (idx_q < best_idx_q));
	assign cand    = ((k_q == '0) || gt_prev) && (!best_valid_q || lt_best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			k_q          <= '0;
			best_valid_q <= 1'b0;
		end else if (cmd.start) begin
			idx_q        <= '0;
			k_q          <= '0;
			best_valid_q <= 1'b0;
		end else if (cmd.next_pass) begin
			idx_q        <= '0;
			k_q          <= CW'(k_q + 1'b1);
			best_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= CW'(idx_q + 1'b1);
			end
			if (cmd.best_upd && cand) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.best_upd && cand) begin
			best_val_q <= rdata_q;
			best_idx_q <= idx_q;
		end
		if (cmd.next_pass) begin
			prev_val_q <= best_val_q;
			prev_idx_q <= best_idx_q;
		end
	end

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_ld) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			m_tdata[47:43] <= '0;
			case (cmd.out_sel)
				OUT_NF: begin
					m_tdata[42:0] <= {32'd0, 7'(n), ST_NOT_FOUND};
					m_tuser       <= 1'b0;
					m_tlast       <= 1'b1;
				end
				OUT_DEL: begin
					m_tdata[42:0] <= {32'd0, 7'(n_m1), ST_OK};
					m_tuser       <= 1'b0;
					m_tlast       <= 1'b1;
				end
				OUT_ELEM: begin
					m_tdata[42:0] <= {rdata_q, 7'(n), ST_OK};
					m_tuser       <= 1'b1;
					m_tlast       <= stat.idx_last;
				end
				OUT_BEST: begin
					m_tdata[42:0] <= {best_val_q, 7'(n), ST_OK};
					m_tuser       <= 1'b1;
					m_tlast       <= stat.k_last;
				end
				default: begin
					m_tdata[42:0] <= {32'd0, 7'(pre_fill), pre_status};
					m_tuser       <= 1'b0;
					m_tlast       <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		stat            = '0;
		stat.cmd        = cmd_q;
		stat.cmd_known  = cmd_known;
		stat.long_op    = long_op;
		stat.match      = (rdata_q == value_q);
		stat.idx_last   = (CW'(idx_q + 1'b1) >= n);
		stat.next_avail = (CW'(idx_q + 1'b1) < n);
		stat.k_last     = (CW'(k_q + 1'b1) >= n);
		stat.out_free   = out_free;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/multi_slot_bounded_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Beat contents
// s_*      in   tuser: cmd; tdata: slot, value, size_arg
// m_*      out  tdata: status, fill_count, elem_value; tuser: elem_valid; tlast: last
//
// Single-result commands: the result is loaded before the next command is accepted.
// Delete: scans entries for the value, then shifts each later entry down, bounded by the fill.
// Read: one output beat per value; sorted read: one selection pass per value,
// set by the one-read-port element memory.
// Reset clears the slot tables; no clearing pass. A stalled m_tready holds the sequencer.
module multi_slot_bounded_list_engine #(
	parameter int NUM_SLOTS = 10,
	parameter int MAX_CAP   = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,  // slot[3:0], value[35:4], size_arg[43:36], zero fill
	input  wire  [3:0]  s_tuser,  // cmd[3:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // status[3:0], fill_count[10:4], elem_value[42:11], zero fill
	output logic [0:0]  m_tuser,  // elem_valid[0]
	output logic        m_tlast
);
	import msble_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	msble_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (ctl)
	);

	msble_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.MAX_CAP   (MAX_CAP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (ctl),
		.stat     (stat)
	);

endmodule
`default_nettype wire
